// File: hw/rtl/lgrs_pkg.sv
// Shared types and constants for the Life row-stream generation engine.
package lgrs_pkg;

    localparam int ROW_W = 32;
    localparam int NBR_CNT_W = 4;
    localparam int WIN_W = 9;
    localparam int WIN_CENTRE = 4;

    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [WIN_W-1:0] window_t;

    typedef struct packed {
        row_t cells;
        logic last;
    } out_word_t;

    // mask of the columns that lie inside the grid
    function automatic row_t col_mask(input int cols);
        row_t m;
        m = '0;
        for (int k = 0; k < ROW_W; k++) begin
            m[k] = (k < cols);
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/life_generation_row_stream_top.sv
// Life row stream: output words for an accepted input word are registered in the output queue.
// One input word per cycle unless stalled; a last row yields two output words after a held row.
// A four-entry output queue absorbs the extra flush word, so input stalls only under backpressure.
// Reset (aresetn low, synchronous): row history cleared, output queue emptied, s_tready high.
// All 32 column lanes of both row evaluators work in the acceptance cycle.
module life_generation_row_stream_top #(
    parameter int GRID_COLUMNS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lgrs_pkg::row_t s_tdata,   // [31:0] row_cells
    input  logic           s_tlast,   // last_row
    output logic           m_tvalid,
    input  logic           m_tready,
    output lgrs_pkg::row_t m_tdata,   // [31:0] next_row_cells
    output logic           m_tlast    // last_out
);
    import lgrs_pkg::*;

    // columns beyond the 32-bit word are always dead
    localparam int   ACTIVE_COLS = (GRID_COLUMNS < ROW_W) ? GRID_COLUMNS : ROW_W;
    localparam row_t IN_MASK     = col_mask(ACTIVE_COLS);

    // row history
    row_t above_row_reg, above_row_next;
    row_t middle_row_reg, middle_row_next;
    logic have_row_reg, have_row_next;

    // output queue
    out_word_t             q_word_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    logic      in_fire;
    logic      out_fire;
    row_t      in_row;
    row_t      flush_above;
    row_t      body_row;
    row_t      flush_row;
    logic      push0;
    logic      push1;
    out_word_t word0;
    out_word_t word1;

    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = m_tvalid & m_tready;
    assign in_row   = s_tdata & IN_MASK;

    // row above the flushed row once this word is taken in
    assign flush_above = have_row_reg ? middle_row_reg : '0;

    // next generation of the held middle row, with the new row below
    lgrs_row_eval #(.ACTIVE_COLS(ACTIVE_COLS)) u_body_eval (
        .up_row   (above_row_reg),
        .mid_row  (middle_row_reg),
        .down_row (in_row),
        .next_row (body_row)
    );

    // next generation of the incoming row with a dead row below (end of grid)
    lgrs_row_eval #(.ACTIVE_COLS(ACTIVE_COLS)) u_flush_eval (
        .up_row   (flush_above),
        .mid_row  (in_row),
        .down_row ('0),
        .next_row (flush_row)
    );

    // first queued word is the body row when history exists, else the flush row
    assign push0 = in_fire & (have_row_reg | s_tlast);
    assign push1 = in_fire & have_row_reg & s_tlast;
    assign word0 = have_row_reg ? out_word_t'{cells: body_row, last: 1'b0}
                                : out_word_t'{cells: flush_row, last: 1'b1};
    assign word1 = '{cells: flush_row, last: 1'b1};

    always_comb begin
        above_row_next  = above_row_reg;
        middle_row_next = middle_row_reg;
        have_row_next   = have_row_reg;
        if (in_fire) begin
            if (s_tlast) begin
                // end of generation: drop history
                above_row_next  = '0;
                middle_row_next = '0;
                have_row_next   = 1'b0;
            end else begin
                above_row_next  = flush_above;
                middle_row_next = in_row;
                have_row_next   = 1'b1;
            end
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(out_fire);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                    - FIFO_CNT_W'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_row_reg  <= '0;
            middle_row_reg <= '0;
            have_row_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            above_row_reg  <= above_row_next;
            middle_row_reg <= middle_row_next;
            have_row_reg   <= have_row_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
        end
    end

    // queue payload: no reset needed
    always_ff @(posedge aclk) begin
        if (push0) begin
            q_word_reg[wr_ptr_reg] <= word0;
        end
        if (push1) begin
            q_word_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= word1;
        end
    end

    // accept only with room for two words
    assign s_tready = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = q_word_reg[rd_ptr_reg].cells;
    assign m_tlast  = q_word_reg[rd_ptr_reg].last;

endmodule

// File: hw/rtl/lgrs_lane.sv
// One cell lane: neighbour count and B3/S23 rule on a 3x3 window.
module lgrs_lane (
    input  lgrs_pkg::window_t win,
    output logic              next_cell
);
    import lgrs_pkg::*;

    logic [NBR_CNT_W-1:0] nbr_cnt;

    always_comb begin
        nbr_cnt = '0;
        for (int i = 0; i < WIN_W; i++) begin
            if (i != WIN_CENTRE) begin
                nbr_cnt = nbr_cnt + {{(NBR_CNT_W-1){1'b0}}, win[i]};
            end
        end
    end

    // born on exactly three, survive on two or three
    assign next_cell = (nbr_cnt == BIRTH_COUNT)
                     | (win[WIN_CENTRE] & (nbr_cnt == SURVIVE_COUNT));

endmodule

// File: hw/rtl/lgrs_row_eval.sv
// Row evaluator: one lane per column, merged into a masked next-generation row.
module lgrs_row_eval #(
    parameter int ACTIVE_COLS = 32
) (
    input  lgrs_pkg::row_t up_row,
    input  lgrs_pkg::row_t mid_row,
    input  lgrs_pkg::row_t down_row,
    output lgrs_pkg::row_t next_row
);
    import lgrs_pkg::*;

    localparam row_t COL_MASK = col_mask(ACTIVE_COLS);

    logic [ROW_W+1:0] up_pad;
    logic [ROW_W+1:0] mid_pad;
    logic [ROW_W+1:0] down_pad;
    row_t             lane_out;

    // pad with dead cells beyond both edges
    assign up_pad   = {1'b0, up_row, 1'b0};
    assign mid_pad  = {1'b0, mid_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    for (genvar k = 0; k < ROW_W; k++) begin : g_lane
        lgrs_lane u_lane (
            .win       ({down_pad[k+2:k], mid_pad[k+2], mid_pad[k+1], mid_pad[k],
                         up_pad[k+2:k]}),
            .next_cell (lane_out[k])
        );
    end

    // merge: drop columns outside the grid
    assign next_row = lane_out & COL_MASK;

endmodule

// File: hw/rtl/lgrs_checker.sv
// Port-level checker for the Life row stream, bound to the top level.
module lgrs_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input lgrs_pkg::row_t s_tdata,
    input logic           s_tlast,
    input logic           m_tvalid,
    input logic           m_tready,
    input lgrs_pkg::row_t m_tdata,
    input logic           m_tlast
);
    import lgrs_pkg::*;

    // reset empties the queue and opens the input
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear output queue");

    // input only stalls while output words are pending
    a_stall_needs_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a last row always yields at least its flush word
    a_last_yields_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("last row produced no output word");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind life_generation_row_stream_top lgrs_checker u_lgrs_checker (.*);
